// ===== hdl/rti_pkg.sv =====
// Shared constants for the ray/triangle intersection core.
// Field widths, stream packing widths and configuration register indexes.
// No dependencies.
package rti_pkg;

	localparam int FIELD_W    = 21;
	localparam int DIST_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int VERT_W     = 63;
	localparam int REG_IDX_W  = 2;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 96;

	localparam logic [REG_IDX_W-1:0] REG_VERTEX_ONE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_TWO   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_THREE = 2'd2;

endpackage

// ===== hdl/ray_triangle_intersect_core.sv =====
// Ray/triangle intersection core: Cramer's rule determinants, a pipelined
// restoring divider for t, and the hit point computation. Depends on rti_pkg.

// The core takes one ray per cycle while its output is not stalled and
// returns one result item per ray, in order. The pipeline has eight
// stages for the determinants (all multipliers split to at most about 24x22
// bits), 32 divider stages that each resolve one bit of the Q16.16 distance,
// and two stages for the hit point. The whole pipeline advances whenever the
// output register is empty or being taken, so a stall on the output side
// holds every item in place. A miss returns hit 0 with all data zero.
// The user must write the triangle through the configuration port only
// while no ray is in flight (not enforced by the core); index 3 is ignored.
module ray_triangle_intersect_core
	import rti_pkg::*;
#(
	parameter int COORD_WIDTH = 21
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [VERT_W-1:0]       cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, then two zero bits
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// distance, point_x, point_y, point_z, then one zero bit
	output logic [OUT_DATA_W-1:0]   m_axis_tdata,
	// hit
	output logic [0:0]              m_axis_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int DFW = W + 1;
	localparam int XW  = 2 * W + 3;
	localparam int PW  = XW + DFW;
	localparam int SW  = PW + 3;
	localparam int UW  = SW - 1;
	localparam int LB  = W + 2;
	localparam int RW  = UW + DIST_W;
	localparam int PRW = W + DIST_W + 1;
	localparam int DV0 = 8;
	localparam int DVN = DV0 + DIST_W;

	localparam logic signed [PRW:0] CMAX = (PRW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [PRW:0] CMIN = -CMAX - (PRW+1)'(1);

	typedef struct packed {
		logic            vld;
		logic            hit;
		logic            sat;
		logic [3*W-1:0]  org;
		logic [3*W-1:0]  dir;
		logic [UW-1:0]   mabs;
		logic [RW-1:0]   rem;
		logic [DIST_W-1:0] quo;
	} dv_t;

	logic adv;
	logic [VERT_W-1:0] vert_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_q[0] <= '0;
			vert_q[1] <= '0;
			vert_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_ONE:   vert_q[0] <= cfg_data;
				REG_VERTEX_TWO:   vert_q[1] <= cfg_data;
				REG_VERTEX_THREE: vert_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge vectors a,b,c = V1-V2 and d,e,f = V1-V3 follow the registers.
	logic signed [W-1:0]   p1 [3];
	logic signed [DFW-1:0] e12 [3];
	logic signed [DFW-1:0] e13 [3];
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			p1[n]  = $signed(vert_q[0][n*W +: W]);
			e12[n] = DFW'(p1[n]) - DFW'($signed(vert_q[1][n*W +: W]));
			e13[n] = DFW'(p1[n]) - DFW'($signed(vert_q[2][n*W +: W]));
		end
	end

	// Stage 1: capture the ray and form j,k,l = V1-O.
	logic                 vld_s1;
	logic [3*W-1:0]       org_s1, dir_s1;
	logic signed [DFW-1:0] jkl_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 3; n++) begin
				org_s1[n*W +: W] <= s_axis_tdata[n*FIELD_W +: W];
				dir_s1[n*W +: W] <= s_axis_tdata[(n+3)*FIELD_W +: W];
				jkl_s1[n] <= DFW'(p1[n]) - DFW'($signed(s_axis_tdata[n*FIELD_W +: W]));
			end
		end
	end

	// Stage 2: the twelve two-term products of the cross terms.
	logic signed [DFW-1:0] dr1 [3];
	logic signed [XW-2:0]  ma [12];
	logic signed [XW-2:0]  mb [12];
	always_comb begin
		for (int n = 0; n < 3; n++) dr1[n] = DFW'($signed(dir_s1[n*W +: W]));
		ma[0]  = (XW-1)'(e13[1]);  mb[0]  = (XW-1)'(dr1[2]);
		ma[1]  = (XW-1)'(dr1[1]);  mb[1]  = (XW-1)'(e13[2]);
		ma[2]  = (XW-1)'(dr1[0]);  mb[2]  = (XW-1)'(e13[2]);
		ma[3]  = (XW-1)'(e13[0]);  mb[3]  = (XW-1)'(dr1[2]);
		ma[4]  = (XW-1)'(e13[0]);  mb[4]  = (XW-1)'(dr1[1]);
		ma[5]  = (XW-1)'(e13[1]);  mb[5]  = (XW-1)'(dr1[0]);
		ma[6]  = (XW-1)'(e12[0]);  mb[6]  = (XW-1)'(jkl_s1[1]);
		ma[7]  = (XW-1)'(jkl_s1[0]); mb[7]  = (XW-1)'(e12[1]);
		ma[8]  = (XW-1)'(jkl_s1[0]); mb[8]  = (XW-1)'(e12[2]);
		ma[9]  = (XW-1)'(e12[0]);  mb[9]  = (XW-1)'(jkl_s1[2]);
		ma[10] = (XW-1)'(e12[1]);  mb[10] = (XW-1)'(jkl_s1[2]);
		ma[11] = (XW-1)'(jkl_s1[1]); mb[11] = (XW-1)'(e12[2]);
	end

	logic                  vld_s2;
	logic [3*W-1:0]        org_s2, dir_s2;
	logic signed [DFW-1:0] jkl_s2 [3];
	logic signed [XW-2:0]  mp_s2 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
			jkl_s2 <= jkl_s1;
			for (int k = 0; k < 12; k++) mp_s2[k] <= ma[k] * mb[k];
		end
	end

	// Stage 3: cross terms ei-hf, gf-di, dh-eg, ak-jb, jc-al, bl-kc.
	logic                  vld_s3;
	logic [3*W-1:0]        org_s3, dir_s3;
	logic signed [DFW-1:0] jkl_s3 [3];
	logic signed [XW-1:0]  cr_s3 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s3 <= org_s2;
			dir_s3 <= dir_s2;
			jkl_s3 <= jkl_s2;
			for (int k = 0; k < 6; k++)
				cr_s3[k] <= XW'(mp_s2[2*k]) - XW'(mp_s2[2*k+1]);
		end
	end

	// Stage 4: each wide cross term times a narrow factor, split in two halves.
	logic signed [XW-1:0]  xop [12];
	logic signed [DFW-1:0] yop [12];
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			xop[n]   = cr_s3[n];   yop[n]   = e12[n];
			xop[3+n] = cr_s3[3+n]; yop[3+n] = e13[2-n];
			xop[6+n] = cr_s3[3+n]; yop[6+n] = DFW'($signed(dir_s3[(2-n)*W +: W]));
			xop[9+n] = cr_s3[n];   yop[9+n] = jkl_s3[n];
		end
	end

	logic                 vld_s4;
	logic [3*W-1:0]       org_s4, dir_s4;
	logic signed [PW-1:0] plo_s4 [12];
	logic signed [PW-1:0] phi_s4 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s4 <= org_s3;
			dir_s4 <= dir_s3;
			for (int k = 0; k < 12; k++) begin
				plo_s4[k] <= PW'($signed({1'b0, xop[k][LB-1:0]})) * PW'(yop[k]);
				phi_s4[k] <= PW'($signed(xop[k][XW-1:LB])) * PW'(yop[k]);
			end
		end
	end

	// Stage 5: recombine the halves.
	logic                 vld_s5;
	logic [3*W-1:0]       org_s5, dir_s5;
	logic signed [PW-1:0] pr_s5 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s5 <= org_s4;
			dir_s5 <= dir_s4;
			for (int k = 0; k < 12; k++) pr_s5[k] <= (phi_s4[k] <<< LB) + plo_s4[k];
		end
	end

	// Stage 6: determinant M and the numerators for t, gamma and beta.
	logic                 vld_s6;
	logic [3*W-1:0]       org_s6, dir_s6;
	logic signed [SW-1:0] m_s6, tn_s6, gn_s6, bn_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s6 <= org_s5;
			dir_s6 <= dir_s5;
			m_s6  <= SW'(pr_s5[0]) + SW'(pr_s5[1]) + SW'(pr_s5[2]);
			tn_s6 <= -(SW'(pr_s5[3]) + SW'(pr_s5[4]) + SW'(pr_s5[5]));
			gn_s6 <= SW'(pr_s5[6]) + SW'(pr_s5[7]) + SW'(pr_s5[8]);
			bn_s6 <= SW'(pr_s5[9]) + SW'(pr_s5[10]) + SW'(pr_s5[11]);
		end
	end

	// Stage 7: flip signs so the denominator is positive.
	logic                 vld_s7, mz_s7;
	logic [3*W-1:0]       org_s7, dir_s7;
	logic signed [SW-1:0] ma_s7, tn_s7, gn_s7, bn_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s7 <= org_s6;
			dir_s7 <= dir_s6;
			mz_s7  <= (m_s6 == '0);
			if (m_s6[SW-1]) begin
				ma_s7 <= -m_s6;  tn_s7 <= -tn_s6;
				gn_s7 <= -gn_s6; bn_s7 <= -bn_s6;
			end else begin
				ma_s7 <= m_s6;  tn_s7 <= tn_s6;
				gn_s7 <= gn_s6; bn_s7 <= bn_s6;
			end
		end
	end

	// Stage 8: hit tests and divider setup, the first divider slot.
	dv_t dv_s [DV0:DVN];
	logic miss7, sat7;
	logic signed [SW:0] gb7;
	always_comb begin
		gb7   = (SW+1)'(gn_s7) + (SW+1)'(bn_s7);
		miss7 = mz_s7 || tn_s7[SW-1] || gn_s7[SW-1] || bn_s7[SW-1]
			|| (gn_s7 > ma_s7) || (gb7 > (SW+1)'(ma_s7));
		sat7  = (RW'(tn_s7[UW-1:0]) >= (RW'(ma_s7[UW-1:0]) << FRAC_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[DV0] <= '0;
		end else if (adv) begin
			dv_s[DV0].vld  <= vld_s7;
			dv_s[DV0].hit  <= !miss7;
			dv_s[DV0].sat  <= sat7;
			dv_s[DV0].org  <= org_s7;
			dv_s[DV0].dir  <= dir_s7;
			dv_s[DV0].mabs <= ma_s7[UW-1:0];
			dv_s[DV0].rem  <= RW'(tn_s7[UW-1:0]) << FRAC_W;
			dv_s[DV0].quo  <= '0;
		end
	end

	// Divider: each stage settles one quotient bit, most significant first.
	for (genvar s = DV0 + 1; s <= DVN; s++) begin : g_div
		localparam int BIT = DVN - s;
		logic [RW-1:0] dsh;
		logic          ge;
		always_comb begin
			dsh = RW'(dv_s[s-1].mabs) << BIT;
			ge  = (dv_s[s-1].rem >= dsh);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[s] <= '0;
			end else if (adv) begin
				dv_s[s].vld  <= dv_s[s-1].vld;
				dv_s[s].hit  <= dv_s[s-1].hit;
				dv_s[s].sat  <= dv_s[s-1].sat;
				dv_s[s].org  <= dv_s[s-1].org;
				dv_s[s].dir  <= dv_s[s-1].dir;
				dv_s[s].mabs <= dv_s[s-1].mabs;
				dv_s[s].rem  <= ge ? dv_s[s-1].rem - dsh : dv_s[s-1].rem;
				dv_s[s].quo  <= dv_s[s-1].quo | (DIST_W'(ge) << BIT);
			end
		end
	end

	// Stage 41: distance and direction times distance.
	logic                  vld_s41, hit_s41;
	logic [DIST_W-1:0]     tq_s41;
	logic [3*W-1:0]        org_s41;
	logic signed [PRW-1:0] prod_s41 [3];
	logic [DIST_W-1:0]     tq40;
	assign tq40 = dv_s[DVN].sat ? '1 : dv_s[DVN].quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s41 <= 1'b0;
		else if (adv) vld_s41 <= dv_s[DVN].vld;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s41 <= dv_s[DVN].hit;
			tq_s41  <= tq40;
			org_s41 <= dv_s[DVN].org;
			for (int n = 0; n < 3; n++)
				prod_s41[n] <= PRW'($signed(dv_s[DVN].dir[n*W +: W]))
					* $signed({1'b0, tq40});
		end
	end

	// Stage 42: hit point with floor rounding and saturation, output register.
	logic signed [PRW:0]   pt41 [3];
	logic signed [W-1:0]   pc41 [3];
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			pt41[n] = (PRW+1)'($signed(org_s41[n*W +: W])) + (PRW+1)'(prod_s41[n] >>> FRAC_W);
			if (pt41[n] > CMAX)      pc41[n] = W'(CMAX);
			else if (pt41[n] < CMIN) pc41[n] = W'(CMIN);
			else                     pc41[n] = W'(pt41[n]);
		end
	end

	logic                      vld_s42, hit_s42;
	logic [DIST_W-1:0]         dist_s42;
	logic signed [FIELD_W-1:0] pnt_s42 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s42 <= 1'b0;
		else if (adv) vld_s42 <= vld_s41;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s42  <= hit_s41;
			dist_s42 <= hit_s41 ? tq_s41 : '0;
			for (int n = 0; n < 3; n++)
				pnt_s42[n] <= hit_s41 ? FIELD_W'(pc41[n]) : '0;
		end
	end

	assign adv           = !vld_s42 || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s42;
	assign m_axis_tuser  = hit_s42;
	assign m_axis_tdata  = {1'b0, pnt_s42[2], pnt_s42[1], pnt_s42[0], dist_s42};

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("miss item carries nonzero data");
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s1, vld_s4, vld_s7, dv_s[DVN].vld, vld_s41, vld_s42}))
		else $error("pipeline moved during stall");
	a_sat_full_dist: assert property (@(posedge clk) disable iff (!arst_n)
		adv && dv_s[DVN].vld && dv_s[DVN].hit && dv_s[DVN].sat |=> tq_s41 == '1)
		else $error("saturated distance not all ones");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for ray_triangle_intersect_core: streams rays at a
// programmed triangle and checks every result item against typed-in values
// or an exact predictor. Depends on rti_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
	import rti_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CMAX       = 1048575;
	localparam int CMIN       = -1048576;
	localparam int LIMIT      = 200000;
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 60;
	localparam int PHASES     = 8;
	localparam int PHASE_RAYS = 175;
	localparam int NROWS      = 18;

	typedef struct packed {
		logic [FIELD_W-1:0] dz, dy, dx, oz, oy, ox;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic [FIELD_W-1:0] pz, py, px;
		logic [DIST_W-1:0]  distance;
	} isect_t;

	// Directed rows: triangle (0 = reset, 1 = right triangle with legs of 1024
	// in z = 0), ox, oy, oz, dx, dy, dz, typed-in flag, hit, distance, px, py, pz.
	int script [0:NROWS-1][0:12] = '{
		'{0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 0, 0, 0, 0, 0},
		'{0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1, 0, 0, 0, 0, 0},
		'{0, 256, 256, 1024, 0, 0, -1024,        1, 0, 0, 0, 0, 0},
		'{1, 256, 256, 1024, 0, 0, -1024,        1, 1, 65536, 256, 256, 0},
		'{1, 256, 256, 1024, 0, 0, 1024,         1, 0, 0, 0, 0, 0},
		'{1, 256, 2048, 1024, 0, 0, -1024,       1, 0, 0, 0, 0, 0},
		'{1, 768, 768, 1024, 0, 0, -1024,        1, 0, 0, 0, 0, 0},
		'{1, 256, 256, 1024, 0, 0, 0,            1, 0, 0, 0, 0, 0},
		'{1, 256, 256, 1024, 1024, 0, 0,         1, 0, 0, 0, 0, 0},
		'{1, 512, 512, 1024, 0, 0, -1024,        1, 1, 65536, 512, 512, 0},
		'{1, 0, 0, 1024, 0, 0, -1024,            1, 1, 65536, 0, 0, 0},
		'{1, 256, 256, 0, 0, 0, -1024,           1, 1, 0, 256, 256, 0},
		'{1, 256, 256, CMAX, 0, 0, -1,           0, 0, 0, 0, 0, 0},
		'{1, 256, 256, CMIN, 0, 0, 1,            0, 0, 0, 0, 0, 0},
		'{1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0},
		'{1, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0},
		'{1, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 1024, 256, 256, -1024,        0, 0, 0, 0, 0, 0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [VERT_W-1:0]     cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	logic [VERT_W-1:0] tri_regs [3];
	int                corner [3][3];
	isect_t            pending_isects [$];
	int                errors, rays_sent, results_seen, hits_seen;
	int                holds_wanted, holds_done, hold_left;
	bit                steady;

	ray_triangle_intersect_core #(.COORD_WIDTH(FIELD_W)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("TIMEOUT after %0d cycles, %0d items still expected", LIMIT,
			pending_isects.size());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int sat21(int v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.ox = ox[FIELD_W-1:0];
		r.oy = oy[FIELD_W-1:0];
		r.oz = oz[FIELD_W-1:0];
		r.dx = dx[FIELD_W-1:0];
		r.dy = dy[FIELD_W-1:0];
		r.dz = dz[FIELD_W-1:0];
		return r;
	endfunction

	// Exact Cramer's rule solve against the mirrored triangle registers.
	function automatic isect_t trace_ray(ray_t r);
		logic signed [127:0] v [3][3];
		logic signed [127:0] o [3];
		logic signed [127:0] dv [3];
		logic signed [127:0] a, b, c, d, e, f, g, h, i, j, k, l;
		logic signed [127:0] ei_hf, gf_di, dh_eg, ak_jb, jc_al, bl_kc;
		logic signed [127:0] m, tn, gn, bn, step, p;
		logic [DIST_W-1:0]   tq;
		logic [FIELD_W-1:0]  pt [3];
		isect_t              res;
		res = '0;
		for (int n = 0; n < 3; n++) begin
			for (int w = 0; w < 3; w++)
				v[w][n] = $signed(tri_regs[w][n*FIELD_W +: FIELD_W]);
		end
		o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
		dv[0] = $signed(r.dx); dv[1] = $signed(r.dy); dv[2] = $signed(r.dz);
		a = v[0][0] - v[1][0]; b = v[0][1] - v[1][1]; c = v[0][2] - v[1][2];
		d = v[0][0] - v[2][0]; e = v[0][1] - v[2][1]; f = v[0][2] - v[2][2];
		g = dv[0]; h = dv[1]; i = dv[2];
		ei_hf = e * i - h * f;
		gf_di = g * f - d * i;
		dh_eg = d * h - e * g;
		m = a * ei_hf + b * gf_di + c * dh_eg;
		if (m == 0)
			return res;
		j = v[0][0] - o[0]; k = v[0][1] - o[1]; l = v[0][2] - o[2];
		ak_jb = a * k - j * b;
		jc_al = j * c - a * l;
		bl_kc = b * l - k * c;
		tn = -(f * ak_jb + e * jc_al + d * bl_kc);
		gn = i * ak_jb + h * jc_al + g * bl_kc;
		bn = j * ei_hf + k * gf_di + l * dh_eg;
		if (m < 0) begin
			m = -m; tn = -tn; gn = -gn; bn = -bn;
		end
		if (tn < 0 || gn < 0 || bn < 0 || gn > m || gn + bn > m)
			return res;
		if (tn >= (m <<< FRAC_W))
			tq = '1;
		else
			tq = DIST_W'((tn <<< FRAC_W) / m);
		for (int n = 0; n < 3; n++) begin
			// Arithmetic shift gives the floor for negative products as well.
			step = (dv[n] * $signed({96'd0, tq})) >>> FRAC_W;
			p = o[n] + step;
			if (p > CMAX) p = CMAX;
			if (p < CMIN) p = CMIN;
			pt[n] = p[FIELD_W-1:0];
		end
		res.hit = 1'b1;
		res.distance = tq;
		res.px = pt[0];
		res.py = pt[1];
		res.pz = pt[2];
		return res;
	endfunction

	// Aims at a random point of the triangle from a nearby origin, so that
	// most rays land close to the edges and the interior.
	function automatic ray_t aimed_ray(int span);
		int u, w, sh;
		int o [3];
		int t [3];
		int d [3];
		u = $urandom_range(256);
		w = $urandom_range(256 - u);
		sh = $urandom_range(2);
		for (int n = 0; n < 3; n++) begin
			t[n] = corner[0][n] + ((corner[1][n] - corner[0][n]) * u
				+ (corner[2][n] - corner[0][n]) * w) / 256;
			o[n] = sat21(t[n] + spread(span));
			d[n] = sat21((t[n] - o[n]) >>> sh);
		end
		if ($urandom_range(19) == 0)
			d[0] = -d[0];
		return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH item %0d %s: got %0h, expected %0h", results_seen, what,
			got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (holds_wanted != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 7);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			isect_t want;
			isect_t got;
			got = {m_axis_tuser[0], m_axis_tdata[3*FIELD_W+DIST_W-1:0]};
			if (pending_isects.size() == 0) begin
				flag_mismatch("unexpected result", 64'(got), 64'd0);
			end else begin
				want = pending_isects.pop_front();
				if (got.hit != want.hit) flag_mismatch("hit", got.hit, want.hit);
				if (got.distance != want.distance)
					flag_mismatch("distance", got.distance, want.distance);
				if (got.px != want.px) flag_mismatch("point_x", got.px, want.px);
				if (got.py != want.py) flag_mismatch("point_y", got.py, want.py);
				if (got.pz != want.pz) flag_mismatch("point_z", got.pz, want.pz);
			end
			if (got.hit) hits_seen++;
			results_seen++;
		end
	end

	task automatic send_ray(ray_t r, bit typed, isect_t given);
		if (!steady && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_isects.push_back(typed ? given : trace_ray(r));
		rays_sent++;
	endtask

	// The sender stops until every result is back, then lets the pipe settle.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_isects.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all three vertices from corner[], optionally with a stray write
	// to the unused index that the core must ignore.
	task automatic program_triangle(bit stray);
		for (int w = 0; w < 3; w++) begin
			cfg_we <= 1'b1;
			cfg_index <= (w == 0) ? REG_VERTEX_ONE : (w == 1) ? REG_VERTEX_TWO
				: REG_VERTEX_THREE;
			tri_regs[w] = {corner[w][2][FIELD_W-1:0], corner[w][1][FIELD_W-1:0],
				corner[w][0][FIELD_W-1:0]};
			cfg_data <= tri_regs[w];
			@(posedge clk);
		end
		if (stray) begin
			cfg_index <= REG_SPARE;
			cfg_data <= VERT_W'({$urandom, $urandom});
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic void set_corner(int w, int x, int y, int z);
		corner[w][0] = x;
		corner[w][1] = y;
		corner[w][2] = z;
	endfunction

	initial begin
		int     tri_now, span, sc;
		isect_t given;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_VERTEX_ONE;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		errors = 0; rays_sent = 0; results_seen = 0; hits_seen = 0;
		holds_wanted = 0; holds_done = 0; hold_left = 0; steady = 0;
		for (int w = 0; w < 3; w++) tri_regs[w] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tri_now = 0;
		for (int row = 0; row < NROWS; row++) begin
			if (script[row][0] != tri_now) begin
				drain();
				set_corner(0, 0, 0, 0);
				set_corner(1, 1024, 0, 0);
				set_corner(2, 0, 1024, 0);
				program_triangle(1'b1);
				tri_now = script[row][0];
			end
			given.hit = script[row][8][0];
			given.distance = script[row][9];
			given.px = script[row][10][FIELD_W-1:0];
			given.py = script[row][11][FIELD_W-1:0];
			given.pz = script[row][12][FIELD_W-1:0];
			send_ray(make_ray(script[row][1], script[row][2], script[row][3],
				script[row][4], script[row][5], script[row][6]),
				script[row][7] != 0, given);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				set_corner(0, CMIN, CMIN, CMIN);
				set_corner(1, CMAX, CMIN, CMAX);
				set_corner(2, CMIN, CMAX, 0);
				sc = CMAX;
			end else if (ph == 1) begin
				// Every vertex the same: the triangle is degenerate.
				for (int w = 0; w < 3; w++) set_corner(w, CMAX, CMAX, CMAX);
				sc = CMAX;
			end else begin
				case (ph % 4)
					0: sc = 64;
					1: sc = 1024;
					2: sc = 65536;
					default: sc = CMAX;
				endcase
				for (int w = 0; w < 3; w++)
					set_corner(w, spread(sc), spread(sc), spread(sc));
			end
			program_triangle(ph == 3);
			span = (sc > CMAX / 2) ? CMAX : 2 * sc;
			steady = (ph == 3);
			if (ph == 2) holds_wanted++;
			for (int n = 0; n < PHASE_RAYS; n++) begin
				if ($urandom_range(99) < 85)
					send_ray(aimed_ray(span), 1'b0, '0);
				else
					send_ray(ray_t'($bits(ray_t)'({$urandom, $urandom, $urandom,
						$urandom})), 1'b0, '0);
			end
			steady = 0;
		end

		drain();
		$display("Checked %0d rays (%0d hits) over %0d triangles, including extremes,",
			results_seen, hits_seen, PHASES + 2);
		$display("a degenerate triangle, output back-pressure and idle-free streaming.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
